// ===== src/stack_type_verifier_macros.svh =====
// Assertion macros shared by the stack type verifier modules.
`ifndef STACK_TYPE_VERIFIER_MACROS_SVH
`define STACK_TYPE_VERIFIER_MACROS_SVH

// Same-cycle implication.
`define STV_ASSERT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/stv_pkg.sv =====
// Types and constants for the stack type verifier.
package stv_pkg;

   localparam int TYPE_BITS   = 3;
   localparam int MAX_INPUTS  = 3;
   localparam int MAX_OUTPUTS = 2;
   localparam int IN_SLOTS    = 3;
   localparam int OUT_SLOTS   = 2;
   localparam int IN_CAP      = (MAX_INPUTS < IN_SLOTS) ? MAX_INPUTS : IN_SLOTS;
   localparam int OUT_CAP     = (MAX_OUTPUTS < OUT_SLOTS) ? MAX_OUTPUTS : OUT_SLOTS;

   localparam int ACTION_W = 4;
   localparam int INDEX_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int NUM_W    = 2;
   localparam int STATUS_W = 3;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd1024;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BEGIN = 4'd0,
      ACT_HALT  = 4'd1,
      ACT_NOP   = 4'd2,
      ACT_PUSH  = 4'd3,
      ACT_DROP  = 4'd4,
      ACT_DUP   = 4'd5,
      ACT_SWAP  = 4'd6,
      ACT_TYPED = 4'd7
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_HALTED      = 3'd1,
      ST_OVERFLOW    = 3'd2,
      ST_UNDERFLOW   = 3'd3,
      ST_MISMATCH    = 3'd4,
      ST_UNSUPPORTED = 3'd5,
      ST_STOPPED     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ADDR_POS,
      ADDR_TOP,
      ADDR_NEXT
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_PUSH,
      WD_RDATA,
      WD_TEMP,
      WD_OUT
   } wdata_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } cnt_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DUP,
      S_SWAP_A,
      S_SWAP_B,
      S_SWAP_C,
      S_POP,
      S_CHECK,
      S_PUSH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic          req_ready;
      logic          rd_en;
      logic          wr_en;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      cnt_op_type    cnt_op;
      logic          set_status;
      status_type    status;
      logic          set_mismatch;
      logic          set_stop;
      logic          clr_stop;
      logic          save_temp;
      logic          in_dec;
      logic          out_inc;
      logic          rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                req_valid;
      logic                stopped;
      logic                can_push;
      logic                empty;
      logic                idx_ok;
      logic                in_done;
      logic                out_done;
      logic                mismatch;
      logic                rsp_free;
   } dp_sts_type;

endpackage

// ===== src/stv_req_if.sv =====
// Request channel: one instruction per beat.
interface stv_req_if;
   import stv_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [TYPE_BITS-1:0] push_type;
   logic [INDEX_W-1:0]   stack_index;
   logic [NUM_W-1:0]     in_count;
   logic [TYPE_BITS-1:0] in_type_0;
   logic [TYPE_BITS-1:0] in_type_1;
   logic [TYPE_BITS-1:0] in_type_2;
   logic [NUM_W-1:0]     out_count;
   logic [TYPE_BITS-1:0] out_type_0;
   logic [TYPE_BITS-1:0] out_type_1;

   modport source (
      output valid, action, push_type, stack_index, in_count, in_type_0, in_type_1,
             in_type_2, out_count, out_type_0, out_type_1,
      input  ready
   );

   modport sink (
      input  valid, action, push_type, stack_index, in_count, in_type_0, in_type_1,
             in_type_2, out_count, out_type_0, out_type_1,
      output ready
   );
endinterface

// ===== src/stv_rsp_if.sv =====
// Response channel: one check result per beat.
interface stv_rsp_if;
   import stv_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [COUNT_W-1:0]   depth;
   logic [TYPE_BITS-1:0] wanted_type;
   logic [TYPE_BITS-1:0] found_type;

   modport source (
      output valid, status, depth, wanted_type, found_type,
      input  ready
   );

   modport sink (
      input  valid, status, depth, wanted_type, found_type,
      output ready
   );
endinterface

// ===== src/stv_datapath.sv =====
// Datapath: instruction registers, type stack memory, depth, stop flag and response register.
`include "stack_type_verifier_macros.svh"

module stv_datapath #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   stv_req_if.sink                   req_ch,
   stv_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [stv_pkg::COUNT_W-1:0] csr_wr_data,
   input  stv_pkg::dp_cmd_type       cmd,
   output stv_pkg::dp_sts_type       sts
);
   import stv_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [TYPE_BITS-1:0] stack_mem_ff [STACK_DEPTH];
   logic [TYPE_BITS-1:0] rdata_ff;
   logic [TYPE_BITS-1:0] temp_ff;
   logic [TYPE_BITS-1:0] wdata;
   logic [TYPE_BITS-1:0] want;
   logic [ADDR_W-1:0]    addr;

   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [COUNT_W-1:0]   limit_ff;
   logic [COUNT_W-1:0]   eff_limit;
   logic [COUNT_W-1:0]   pos;
   logic                 stopped_ff;

   logic [ACTION_W-1:0]  action_ff;
   logic [TYPE_BITS-1:0] push_type_ff;
   logic [INDEX_W-1:0]   stack_index_ff;
   logic [TYPE_BITS-1:0] in_type_ff [IN_SLOTS];
   logic [TYPE_BITS-1:0] out_type_ff [OUT_SLOTS];
   logic [NUM_W-1:0]     in_left_ff;
   logic [NUM_W-1:0]     out_cnt_ff;
   logic [NUM_W-1:0]     out_pos_ff;
   logic [NUM_W-1:0]     nin;
   logic [NUM_W-1:0]     nout;

   status_type           status_ff;
   logic [TYPE_BITS-1:0] expected_ff;
   logic [TYPE_BITS-1:0] found_ff;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_depth_ff;
   logic [TYPE_BITS-1:0] rsp_expected_ff;
   logic [TYPE_BITS-1:0] rsp_found_ff;

   logic                 accept;

   assign accept       = req_ch.valid && cmd.req_ready;
   assign req_ch.ready = cmd.req_ready;

   assign nin  = (int'(req_ch.in_count) > IN_CAP) ? NUM_W'(IN_CAP) : req_ch.in_count;
   assign nout = (int'(req_ch.out_count) > OUT_CAP) ? NUM_W'(OUT_CAP) : req_ch.out_count;

   assign want = in_type_ff[in_left_ff - NUM_W'(1)];
   assign pos  = count_ff - COUNT_W'(1) - COUNT_W'(stack_index_ff);

   always_comb begin
      if (32'(limit_ff) < STACK_DEPTH) begin
         eff_limit = limit_ff;
      end else begin
         eff_limit = COUNT_W'(STACK_DEPTH);
      end
   end

   always_comb begin
      case (cmd.addr_sel)
         ADDR_POS:  addr = ADDR_W'(pos);
         ADDR_TOP:  addr = ADDR_W'(count_ff - COUNT_W'(1));
         ADDR_NEXT: addr = ADDR_W'(count_ff);
         default:   addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wdata_sel)
         WD_PUSH:  wdata = push_type_ff;
         WD_RDATA: wdata = rdata_ff;
         WD_TEMP:  wdata = temp_ff;
         WD_OUT:   wdata = out_type_ff[out_pos_ff[0]];
         default:  wdata = '0;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + COUNT_W'(1);
         CNT_DEC:   count_in = count_ff - COUNT_W'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   // single-port type stack
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         stack_mem_ff[addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= stack_mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.clr_stop) begin
            stopped_ff <= 1'b0;
         end else if (cmd.set_stop) begin
            stopped_ff <= 1'b1;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff      <= req_ch.action;
         push_type_ff   <= req_ch.push_type;
         stack_index_ff <= req_ch.stack_index;
         in_type_ff[0]  <= req_ch.in_type_0;
         in_type_ff[1]  <= req_ch.in_type_1;
         in_type_ff[2]  <= req_ch.in_type_2;
         out_type_ff[0] <= req_ch.out_type_0;
         out_type_ff[1] <= req_ch.out_type_1;
         in_left_ff     <= nin;
         out_cnt_ff     <= nout;
         out_pos_ff     <= '0;
         status_ff      <= ST_OK;
         expected_ff    <= '0;
         found_ff       <= '0;
      end else begin
         if (cmd.in_dec) begin
            in_left_ff <= in_left_ff - NUM_W'(1);
         end
         if (cmd.out_inc) begin
            out_pos_ff <= out_pos_ff + NUM_W'(1);
         end
         if (cmd.set_status) begin
            status_ff <= cmd.status;
         end
         if (cmd.set_mismatch) begin
            expected_ff <= want;
            found_ff    <= rdata_ff;
         end
      end
      if (cmd.save_temp) begin
         temp_ff <= rdata_ff;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_depth_ff    <= count_ff;
         rsp_expected_ff <= expected_ff;
         rsp_found_ff    <= found_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.depth       = rsp_depth_ff;
   assign rsp_ch.wanted_type = rsp_expected_ff;
   assign rsp_ch.found_type  = rsp_found_ff;

   always_comb begin
      sts.action    = action_ff;
      sts.req_valid = req_ch.valid;
      sts.stopped   = stopped_ff;
      sts.can_push  = count_ff < eff_limit;
      sts.empty     = count_ff == '0;
      sts.idx_ok    = COUNT_W'(stack_index_ff) < count_ff;
      sts.in_done   = in_left_ff == '0;
      sts.out_done  = out_pos_ff == out_cnt_ff;
      sts.mismatch  = rdata_ff != want;
      sts.rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   end

   `STV_ASSERT(a_count_cap, clock, reset, 1'b1, 32'(count_ff) <= STACK_DEPTH,
      "stack depth beyond memory size")
   `STV_ASSERT(a_mm_types, clock, reset, rsp_valid_ff && rsp_status_ff == ST_MISMATCH,
      rsp_expected_ff != rsp_found_ff, "mismatch beat with equal types")
   `STV_ASSERT_NEXT(a_begin_clears, clock, reset, cmd.rsp_load && action_ff == ACT_BEGIN,
      count_ff == '0 && !stopped_ff, "begin left stack or stop flag set")

endmodule

// ===== src/stv_ctrl.sv =====
// Controller: sequences each instruction over the single-port type stack.
`include "stack_type_verifier_macros.svh"

module stv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  stv_pkg::dp_sts_type sts,
   output stv_pkg::dp_cmd_type cmd
);
   import stv_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            if (sts.action == ACT_BEGIN) begin
               cmd.cnt_op   = CNT_CLEAR;
               cmd.clr_stop = 1'b1;
            end else if (sts.stopped) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_STOPPED;
            end else begin
               case (sts.action)
                  ACT_HALT: begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_HALTED;
                     cmd.set_stop   = 1'b1;
                  end
                  ACT_NOP: begin
                     cmd.cnt_op = CNT_HOLD;
                  end
                  ACT_PUSH: begin
                     if (sts.can_push) begin
                        cmd.wr_en     = 1'b1;
                        cmd.addr_sel  = ADDR_NEXT;
                        cmd.wdata_sel = WD_PUSH;
                        cmd.cnt_op    = CNT_INC;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_OVERFLOW;
                        cmd.set_stop   = 1'b1;
                     end
                  end
                  ACT_DROP: begin
                     if (!sts.empty) begin
                        cmd.cnt_op = CNT_DEC;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_UNDERFLOW;
                        cmd.set_stop   = 1'b1;
                     end
                  end
                  ACT_DUP, ACT_SWAP: begin
                     if (sts.idx_ok) begin
                        cmd.rd_en    = 1'b1;
                        cmd.addr_sel = ADDR_POS;
                        state_in     = (sts.action == ACT_DUP) ? S_DUP : S_SWAP_A;
                     end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_UNDERFLOW;
                        cmd.set_stop   = 1'b1;
                     end
                  end
                  ACT_TYPED: begin
                     state_in = S_POP;
                  end
                  default: begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_UNSUPPORTED;
                     cmd.set_stop   = 1'b1;
                  end
               endcase
            end
         end
         S_DUP: begin
            state_in = S_RESP;
            if (sts.can_push) begin
               cmd.wr_en     = 1'b1;
               cmd.addr_sel  = ADDR_NEXT;
               cmd.wdata_sel = WD_RDATA;
               cmd.cnt_op    = CNT_INC;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OVERFLOW;
               cmd.set_stop   = 1'b1;
            end
         end
         S_SWAP_A: begin
            cmd.save_temp = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.addr_sel  = ADDR_TOP;
            state_in      = S_SWAP_B;
         end
         S_SWAP_B: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = ADDR_POS;
            cmd.wdata_sel = WD_RDATA;
            state_in      = S_SWAP_C;
         end
         S_SWAP_C: begin
            cmd.wr_en     = 1'b1;
            cmd.addr_sel  = ADDR_TOP;
            cmd.wdata_sel = WD_TEMP;
            state_in      = S_RESP;
         end
         S_POP: begin
            if (sts.in_done) begin
               state_in = S_PUSH;
            end else if (sts.empty) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_UNDERFLOW;
               cmd.set_stop   = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.rd_en    = 1'b1;
               cmd.addr_sel = ADDR_TOP;
               cmd.cnt_op   = CNT_DEC;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.mismatch) begin
               cmd.set_mismatch = 1'b1;
               cmd.set_status   = 1'b1;
               cmd.status       = ST_MISMATCH;
               cmd.set_stop     = 1'b1;
               state_in         = S_RESP;
            end else begin
               cmd.in_dec = 1'b1;
               state_in   = S_POP;
            end
         end
         S_PUSH: begin
            if (sts.out_done) begin
               state_in = S_RESP;
            end else if (sts.can_push) begin
               cmd.wr_en     = 1'b1;
               cmd.addr_sel  = ADDR_NEXT;
               cmd.wdata_sel = WD_OUT;
               cmd.cnt_op    = CNT_INC;
               cmd.out_inc   = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OVERFLOW;
               cmd.set_stop   = 1'b1;
               state_in       = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `STV_ASSERT(a_one_port, clock, reset, 1'b1, !(cmd.rd_en && cmd.wr_en), "read and write on the stack port in one cycle")

endmodule

// ===== src/stack_type_verifier.sv =====
// Stack type verifier top level: controller and datapath around a one-port type stack.
// One stack access per cycle. Begin, halt, nop, push, drop, unsupported, stopped and too-deep
// dup or swap finish in decode; dup adds a write state, swap a read and two write states; a typed
// op pops and checks each input type, then pushes each result type, and ends early on failure.
// A result waits in the response register while the next request beat is taken.
// Reset (synchronous): empty stack, not stopped, stack_limit 1024; stack memory not cleared.
module stack_type_verifier #(
   parameter int STACK_DEPTH = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   stv_req_if.sink                     req_ch,
   stv_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [stv_pkg::COUNT_W-1:0] csr_wr_data
);
   import stv_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   stv_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   stv_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
